/* rtl/core/bfst_pkg.sv */
// Shared constants, codes and types of the quartic Bezier foot trajectory block.
// No dependencies; every other file in rtl/core refers to it by scoped names.

package bfst_pkg;

    // Curve order and phase format
    localparam int DEGREE          = 4;
    localparam int PHASE_FRAC_BITS = 15;
    localparam int PHASE_W         = 16;

    // Field widths
    localparam int POS_W   = 18;
    localparam int PITCH_W = 16;
    localparam int CLR_W   = 16;
    localparam int LIFT_W  = 19;

    // Output saturation limits, Q2.16 metres
    localparam logic signed [POS_W-1:0] POS_MAX = 18'sd131071;
    localparam logic signed [POS_W-1:0] POS_MIN = -18'sd131072;

    // Angle constants, Q4.13 radians
    localparam logic signed [16:0] PI_Q13      = 17'sd25736;
    localparam logic signed [16:0] TWO_PI_Q13  = 17'sd51472;
    localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;

    // Sine series: nested Horner steps, innermost divisor first
    localparam int SINE_ITERS = 4;
    localparam int unsigned SINE_DIV [SINE_ITERS] = '{72, 42, 20, 6};

    // Binomial weights of the degree-4 Bernstein basis
    localparam int BINOM [DEGREE+1] = '{1, 4, 6, 4, 1};

    // Pipeline depths
    localparam int SINE_LAT  = 16;
    localparam int WGT_LAT   = 5;
    localparam int AXIS_LAT  = 4;
    localparam int ALIGN_LAT = SINE_LAT - WGT_LAT;
    localparam int PIPE_LAT  = SINE_LAT + AXIS_LAT;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURVE_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_CLR   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_CLR  = 2'd2;

    // Start and end point of one request
    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] start_z;
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] end_y;
        logic signed [POS_W-1:0] end_z;
    } points_t;

endpackage

/* rtl/core/bfst_half_sine.sv */
// Pipelined 0.5*sin(pitch) plus second clearance, giving the z lift of control point 2.
// Uses bfst_pkg constants; 16 stages, advances on en.

module bfst_half_sine
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [bfst_pkg::PITCH_W-1:0]  pitch,
    input  logic        [bfst_pkg::CLR_W-1:0]    second_clearance,
    output logic signed [bfst_pkg::LIFT_W-1:0]   lift
);

    localparam int MAG_W    = 14;
    localparam int MAG_SQ_W = 28;
    localparam int H_W      = 31;
    localparam int N_W      = 32;
    localparam int RECIP_W  = 30;
    localparam int S_W      = 31;
    localparam logic [H_W-1:0] ONE_H = 31'h4000_0000;

    typedef struct packed {
        logic [MAG_W-1:0]    mag;
        logic                neg;
        logic [MAG_SQ_W-1:0] mag_sq;
    } sin_carry_t;

    // Range reduction and folding into [0, pi/2]
    logic signed [16:0] ang;
    logic signed [16:0] wrap;
    logic        [16:0] abs_ang;
    logic        [16:0] fold;
    logic [MAG_W-1:0]   mag_s1_reg;
    logic               neg_s1_reg;

    always_comb
    begin
        ang = 17'(pitch);
        if (ang > bfst_pkg::PI_Q13)
        begin
            wrap = ang - bfst_pkg::TWO_PI_Q13;
        end
        else if (ang < -bfst_pkg::PI_Q13)
        begin
            wrap = ang + bfst_pkg::TWO_PI_Q13;
        end
        else
        begin
            wrap = ang;
        end
        abs_ang = wrap[16] ? 17'(-wrap) : 17'(wrap);
        fold    = (abs_ang > bfst_pkg::HALF_PI_Q13) ? (bfst_pkg::PI_Q13 - abs_ang) : abs_ang;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_s1_reg <= fold[MAG_W-1:0];
            neg_s1_reg <= wrap[16];
        end
    end

    // Square of the folded angle; x2 of the series is this value shifted by four
    sin_carry_t carry_s2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry_s2_reg.mag    <= mag_s1_reg;
            carry_s2_reg.neg    <= neg_s1_reg;
            carry_s2_reg.mag_sq <= MAG_SQ_W'(mag_s1_reg) * MAG_SQ_W'(mag_s1_reg);
        end
    end

    // Horner steps: h = 1 - ((x2*h) >> 30) / d, three stages each
    logic [H_W-1:0] h_chain     [bfst_pkg::SINE_ITERS+1];
    sin_carry_t     carry_chain [bfst_pkg::SINE_ITERS+1];

    assign h_chain[0]     = ONE_H;
    assign carry_chain[0] = carry_s2_reg;

    for (genvar g = 0; g < bfst_pkg::SINE_ITERS; g++)
    begin : g_step
        localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / bfst_pkg::SINE_DIV[g]);
        localparam logic [7:0]         DIV8  = 8'(bfst_pkg::SINE_DIV[g]);

        logic [MAG_SQ_W+H_W-1:0] prod_a;
        logic [N_W+RECIP_W-1:0]  prod_b;
        logic [7:0]              qd_lo;
        logic [7:0]              rem;
        logic                    corr;

        logic [N_W-1:0]     n_a_reg;
        sin_carry_t         carry_a_reg;
        logic [RECIP_W-1:0] qe_b_reg;
        logic [7:0]         nlo_b_reg;
        sin_carry_t         carry_b_reg;
        logic [H_W-1:0]     h_c_reg;
        sin_carry_t         carry_c_reg;

        // Product with the running term, scaled back to Q30
        assign prod_a = carry_chain[g].mag_sq * h_chain[g];

        // Quotient estimate by reciprocal, at most one short
        assign prod_b = n_a_reg * RECIP;

        // Remainder check on the low byte, which holds the whole remainder
        assign qd_lo = 8'(qe_b_reg[7:0] * DIV8);
        assign rem   = nlo_b_reg - qd_lo;
        assign corr  = (rem >= DIV8);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_a_reg     <= prod_a[N_W+25:26];
                carry_a_reg <= carry_chain[g];
                qe_b_reg    <= prod_b[N_W+RECIP_W-1:32];
                nlo_b_reg   <= n_a_reg[7:0];
                carry_b_reg <= carry_a_reg;
                h_c_reg     <= ONE_H - H_W'(qe_b_reg) - H_W'(corr);
                carry_c_reg <= carry_b_reg;
            end
        end

        assign h_chain[g+1]     = h_c_reg;
        assign carry_chain[g+1] = carry_c_reg;
    end

    // Final product x*h back to Q30
    logic [MAG_W+H_W-1:0] prod_s;
    logic [S_W-1:0]       s_reg;
    logic                 neg_s_reg;

    assign prod_s = carry_chain[bfst_pkg::SINE_ITERS].mag * h_chain[bfst_pkg::SINE_ITERS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg     <= prod_s[S_W+12:13];
            neg_s_reg <= carry_chain[bfst_pkg::SINE_ITERS].neg;
        end
    end

    // Halve into Q2.16 with rounding, apply sign, add clearance
    logic [31:0]                      rsum;
    logic signed [bfst_pkg::LIFT_W-1:0] half_mag;
    logic signed [bfst_pkg::LIFT_W-1:0] lift_next;
    logic signed [bfst_pkg::LIFT_W-1:0] lift_reg;

    always_comb
    begin
        rsum      = 32'(s_reg) + 32'd16384;
        half_mag  = $signed({2'b00, rsum[31:15]});
        lift_next = $signed({3'b000, second_clearance}) + (neg_s_reg ? -half_mag : half_mag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lift_reg <= lift_next;
        end
    end

    assign lift = lift_reg;

endmodule

/* rtl/core/bfst_weights.sv */
// Bernstein weight pipeline: phase clamp, pair products, weights, group sums by curve mode.
// Uses bfst_pkg for the binomial table; five stages, advances on en.

module bfst_weights
#(
    parameter int FRAC = bfst_pkg::PHASE_FRAC_BITS
)
(
    input  logic                           clk,
    input  logic                           en,
    input  logic                           curve_mode,
    input  logic [bfst_pkg::PHASE_W-1:0]   phase,
    output logic [FRAC+1:0]                a_xz,
    output logic [FRAC+1:0]                b_xz,
    output logic [FRAC+1:0]                a_y,
    output logic [FRAC+1:0]                b_y,
    output logic [FRAC+1:0]                lift1_w,
    output logic [FRAC+1:0]                lift2_w
);

    localparam int TW = FRAC + 1;
    localparam int WW = FRAC + 2;
    localparam int CW = (TW > bfst_pkg::PHASE_W) ? TW : bfst_pkg::PHASE_W;
    localparam int PW = 2 * TW;
    localparam int KW = 2 * TW + 2;
    localparam int NW = bfst_pkg::DEGREE + 1;
    localparam logic [CW-1:0] ONE_C  = CW'(64'd1 << FRAC);
    localparam logic [TW-1:0] ONE_T  = TW'(64'd1 << FRAC);
    localparam logic [PW-1:0] HALF_P = PW'(64'd1 << (FRAC - 1));
    localparam logic [KW-1:0] HALF_K = KW'(64'd1 << (FRAC - 1));

    // Clamp phase to one and form 1 - t
    logic [CW-1:0] ph_ext;
    logic [CW-1:0] t_clamp;
    logic [TW-1:0] t_reg;
    logic [TW-1:0] u_reg;

    assign ph_ext  = CW'(phase);
    assign t_clamp = (ph_ext > ONE_C) ? ONE_C : ph_ext;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= t_clamp[TW-1:0];
            u_reg <= ONE_T - t_clamp[TW-1:0];
        end
    end

    // Rounded pair products t*t, t*u, u*u
    logic [PW-1:0] sq_tt;
    logic [PW-1:0] sq_tu;
    logic [PW-1:0] sq_uu;
    logic [TW-1:0] tt_reg;
    logic [TW-1:0] tu_reg;
    logic [TW-1:0] uu_reg;

    assign sq_tt = t_reg * t_reg + HALF_P;
    assign sq_tu = t_reg * u_reg + HALF_P;
    assign sq_uu = u_reg * u_reg + HALF_P;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tt_reg <= sq_tt[FRAC +: TW];
            tu_reg <= sq_tu[FRAC +: TW];
            uu_reg <= sq_uu[FRAC +: TW];
        end
    end

    // Raw basis products
    logic [PW-1:0] pq_reg [NW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pq_reg[0] <= uu_reg * uu_reg;
            pq_reg[1] <= tu_reg * uu_reg;
            pq_reg[2] <= tu_reg * tu_reg;
            pq_reg[3] <= tt_reg * tu_reg;
            pq_reg[4] <= tt_reg * tt_reg;
        end
    end

    // Scale by binomial weight and round
    logic [KW-1:0] wk    [NW];
    logic [WW-1:0] w_reg [NW];

    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            wk[i] = KW'(pq_reg[i]) * KW'(bfst_pkg::BINOM[i]) + HALF_K;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NW; i++)
            begin
                w_reg[i] <= wk[i][FRAC +: WW];
            end
        end
    end

    // Group weights by which control points share a value
    logic [WW-1:0] a_xz_reg;
    logic [WW-1:0] b_xz_reg;
    logic [WW-1:0] a_y_reg;
    logic [WW-1:0] b_y_reg;
    logic [WW-1:0] lift1_w_reg;
    logic [WW-1:0] lift2_w_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (curve_mode)
            begin
                a_xz_reg    <= w_reg[0];
                b_xz_reg    <= w_reg[1] + w_reg[2] + w_reg[3] + w_reg[4];
                a_y_reg     <= w_reg[0] + w_reg[1] + w_reg[2] + w_reg[3];
                b_y_reg     <= w_reg[4];
                lift1_w_reg <= '0;
                lift2_w_reg <= '0;
            end
            else
            begin
                a_xz_reg    <= w_reg[0] + w_reg[1];
                b_xz_reg    <= w_reg[2] + w_reg[3] + w_reg[4];
                a_y_reg     <= w_reg[0] + w_reg[1];
                b_y_reg     <= w_reg[2] + w_reg[3] + w_reg[4];
                lift1_w_reg <= w_reg[1];
                lift2_w_reg <= w_reg[2];
            end
        end
    end

    assign a_xz    = a_xz_reg;
    assign b_xz    = b_xz_reg;
    assign a_y     = a_y_reg;
    assign b_y     = b_y_reg;
    assign lift1_w = lift1_w_reg;
    assign lift2_w = lift2_w_reg;

endmodule

/* rtl/core/bfst_axis.sv */
// One axis of the curve: weighted sum of start, end and two lift terms, round, saturate.
// Uses bfst_pkg limits; four stages, the last one is the output register.

module bfst_axis
#(
    parameter int FRAC = bfst_pkg::PHASE_FRAC_BITS
)
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic        [FRAC+1:0]               a_w,
    input  logic        [FRAC+1:0]               b_w,
    input  logic        [FRAC+1:0]               c_w,
    input  logic        [FRAC+1:0]               d_w,
    input  logic signed [bfst_pkg::POS_W-1:0]    start_pt,
    input  logic signed [bfst_pkg::POS_W-1:0]    end_pt,
    input  logic signed [bfst_pkg::LIFT_W-1:0]   c_val,
    input  logic signed [bfst_pkg::LIFT_W-1:0]   d_val,
    output logic signed [bfst_pkg::POS_W-1:0]    foot
);

    localparam int PW = FRAC + 3 + bfst_pkg::LIFT_W;
    localparam int SW = PW + 1;
    localparam int VW = PW + 2;
    localparam int QW = VW - FRAC;
    localparam logic signed [VW-1:0] HALF_V = VW'(64'd1 << (FRAC - 1));

    // Four weighted terms
    logic signed [bfst_pkg::LIFT_W-1:0] s_ext;
    logic signed [bfst_pkg::LIFT_W-1:0] e_ext;
    logic signed [PW-1:0] prod_a;
    logic signed [PW-1:0] prod_b;
    logic signed [PW-1:0] prod_c;
    logic signed [PW-1:0] prod_d;
    logic signed [PW-1:0] prod_a_reg;
    logic signed [PW-1:0] prod_b_reg;
    logic signed [PW-1:0] prod_c_reg;
    logic signed [PW-1:0] prod_d_reg;

    assign s_ext  = bfst_pkg::LIFT_W'(start_pt);
    assign e_ext  = bfst_pkg::LIFT_W'(end_pt);
    assign prod_a = $signed({1'b0, a_w}) * s_ext;
    assign prod_b = $signed({1'b0, b_w}) * e_ext;
    assign prod_c = $signed({1'b0, c_w}) * c_val;
    assign prod_d = $signed({1'b0, d_w}) * d_val;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= prod_a;
            prod_b_reg <= prod_b;
            prod_c_reg <= prod_c;
            prod_d_reg <= prod_d;
        end
    end

    // Pairwise sums
    logic signed [SW-1:0] sum_ab_reg;
    logic signed [SW-1:0] sum_cd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_ab_reg <= SW'(prod_a_reg) + SW'(prod_b_reg);
            sum_cd_reg <= SW'(prod_c_reg) + SW'(prod_d_reg);
        end
    end

    // Round half up, floor shift back to Q2.16
    logic signed [VW-1:0] vsum;
    logic signed [QW-1:0] q_reg;

    assign vsum = VW'(sum_ab_reg) + VW'(sum_cd_reg) + HALF_V;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= vsum[VW-1:FRAC];
        end
    end

    // Saturate into the output register
    logic signed [bfst_pkg::POS_W-1:0] foot_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (q_reg > bfst_pkg::POS_MAX)
            begin
                foot_reg <= bfst_pkg::POS_MAX;
            end
            else if (q_reg < bfst_pkg::POS_MIN)
            begin
                foot_reg <= bfst_pkg::POS_MIN;
            end
            else
            begin
                foot_reg <= q_reg[bfst_pkg::POS_W-1:0];
            end
        end
    end

    assign foot = foot_reg;

endmodule

/* rtl/core/bezier_foot_swing_trajectory_top.sv */
// Quartic Bezier foot trajectory: each request (phase, start point, end point, pitch) yields one
// saturated foot position in Q2.16 metres. The block takes one request per clock while no result
// is stalled and returns results in request order, through the 16-stage half-sine pipeline
// (range fold, square, four Horner steps of three stages, product, rounding) followed by four
// axis stages (products, pair sums, rounding, saturation). A result stall freezes the whole
// pipeline, so item_stall follows foot_stall while a result is waiting. Write configuration
// only while no request is in flight; cfg_ready is always high.
// Depends on bfst_pkg, bfst_half_sine, bfst_weights and bfst_axis.

module bezier_foot_swing_trajectory_top
#(
    parameter int PHASE_FRAC_BITS = bfst_pkg::PHASE_FRAC_BITS
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // request channel
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic        [bfst_pkg::PHASE_W-1:0]    phase,
    input  logic signed [bfst_pkg::POS_W-1:0]      start_x,
    input  logic signed [bfst_pkg::POS_W-1:0]      start_y,
    input  logic signed [bfst_pkg::POS_W-1:0]      start_z,
    input  logic signed [bfst_pkg::POS_W-1:0]      end_x,
    input  logic signed [bfst_pkg::POS_W-1:0]      end_y,
    input  logic signed [bfst_pkg::POS_W-1:0]      end_z,
    input  logic signed [bfst_pkg::PITCH_W-1:0]    pitch,
    // result channel
    output logic                                   foot_valid,
    input  logic                                   foot_stall,
    output logic signed [bfst_pkg::POS_W-1:0]      foot_x,
    output logic signed [bfst_pkg::POS_W-1:0]      foot_y,
    output logic signed [bfst_pkg::POS_W-1:0]      foot_z,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [bfst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [bfst_pkg::CLR_W-1:0]      cfg_data
);

    localparam int WW = PHASE_FRAC_BITS + 2;

    // Configuration registers
    logic                          curve_mode_reg;
    logic [bfst_pkg::CLR_W-1:0]    first_clr_reg;
    logic [bfst_pkg::CLR_W-1:0]    second_clr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_mode_reg <= 1'b0;
            first_clr_reg  <= '0;
            second_clr_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bfst_pkg::CFG_CURVE_MODE: curve_mode_reg <= cfg_data[0];
                bfst_pkg::CFG_FIRST_CLR:  first_clr_reg  <= cfg_data;
                bfst_pkg::CFG_SECOND_CLR: second_clr_reg <= cfg_data;
                default:                  curve_mode_reg <= curve_mode_reg;
            endcase
        end
    end

    // Pipeline advance: hold everything while a result waits under stall
    logic                          en;
    logic [bfst_pkg::PIPE_LAT-1:0] vld_reg;

    assign en         = !(vld_reg[bfst_pkg::PIPE_LAT-1] && foot_stall);
    assign item_stall = !en;
    assign foot_valid = vld_reg[bfst_pkg::PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[bfst_pkg::PIPE_LAT-2:0], item_valid};
        end
    end

    // Align phase and points with the half-sine result
    bfst_pkg::points_t             pos_in;
    bfst_pkg::points_t             pos_dly_reg   [bfst_pkg::SINE_LAT];
    logic [bfst_pkg::PHASE_W-1:0]  phase_dly_reg [bfst_pkg::ALIGN_LAT];

    assign pos_in = '{start_x: start_x, start_y: start_y, start_z: start_z,
                      end_x: end_x, end_y: end_y, end_z: end_z};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_dly_reg[0]   <= pos_in;
            phase_dly_reg[0] <= phase;
            for (int i = 1; i < bfst_pkg::SINE_LAT; i++)
            begin
                pos_dly_reg[i] <= pos_dly_reg[i-1];
            end
            for (int i = 1; i < bfst_pkg::ALIGN_LAT; i++)
            begin
                phase_dly_reg[i] <= phase_dly_reg[i-1];
            end
        end
    end

    // Lift of control point 2
    logic signed [bfst_pkg::LIFT_W-1:0] lift2;

    bfst_half_sine u_sine
    (
        .clk              (clk),
        .en               (en),
        .pitch            (pitch),
        .second_clearance (second_clr_reg),
        .lift             (lift2)
    );

    // Bernstein weights grouped by control point
    logic [WW-1:0] a_xz;
    logic [WW-1:0] b_xz;
    logic [WW-1:0] a_y;
    logic [WW-1:0] b_y;
    logic [WW-1:0] lift1_w;
    logic [WW-1:0] lift2_w;

    bfst_weights #(.FRAC(PHASE_FRAC_BITS)) u_wgt
    (
        .clk        (clk),
        .en         (en),
        .curve_mode (curve_mode_reg),
        .phase      (phase_dly_reg[bfst_pkg::ALIGN_LAT-1]),
        .a_xz       (a_xz),
        .b_xz       (b_xz),
        .a_y        (a_y),
        .b_y        (b_y),
        .lift1_w    (lift1_w),
        .lift2_w    (lift2_w)
    );

    // Three axis evaluators
    bfst_pkg::points_t                  pos_al;
    logic signed [bfst_pkg::LIFT_W-1:0] lift1;

    assign pos_al = pos_dly_reg[bfst_pkg::SINE_LAT-1];
    assign lift1  = $signed({3'b000, first_clr_reg});

    bfst_axis #(.FRAC(PHASE_FRAC_BITS)) u_axis_x
    (
        .clk      (clk),
        .en       (en),
        .a_w      (a_xz),
        .b_w      (b_xz),
        .c_w      ('0),
        .d_w      ('0),
        .start_pt (pos_al.start_x),
        .end_pt   (pos_al.end_x),
        .c_val    ('0),
        .d_val    ('0),
        .foot     (foot_x)
    );

    bfst_axis #(.FRAC(PHASE_FRAC_BITS)) u_axis_y
    (
        .clk      (clk),
        .en       (en),
        .a_w      (a_y),
        .b_w      (b_y),
        .c_w      ('0),
        .d_w      ('0),
        .start_pt (pos_al.start_y),
        .end_pt   (pos_al.end_y),
        .c_val    ('0),
        .d_val    ('0),
        .foot     (foot_y)
    );

    bfst_axis #(.FRAC(PHASE_FRAC_BITS)) u_axis_z
    (
        .clk      (clk),
        .en       (en),
        .a_w      (a_xz),
        .b_w      (b_xz),
        .c_w      (lift1_w),
        .d_w      (lift2_w),
        .start_pt (pos_al.start_z),
        .end_pt   (pos_al.end_z),
        .c_val    (lift1),
        .d_val    (lift2),
        .foot     (foot_z)
    );

endmodule

/* rtl/core/bfst_checker.sv */
// Port-level checks for the foot trajectory top level, attached by bind.
// Depends on bfst_pkg for field widths.

module bfst_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                item_valid,
    input logic                                item_stall,
    input logic                                foot_valid,
    input logic                                foot_stall,
    input logic signed [bfst_pkg::POS_W-1:0]   foot_x,
    input logic signed [bfst_pkg::POS_W-1:0]   foot_y,
    input logic signed [bfst_pkg::POS_W-1:0]   foot_z
);

    // Requests are held back only by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (foot_valid && foot_stall))
        else $error("request stalled without a waiting result");

    // A waiting result always holds back new requests
    a_stall_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (foot_valid && foot_stall) |-> item_stall)
        else $error("request taken while result stalled");

    // Nothing comes out once a clock edge has seen reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !foot_valid)
        else $error("result valid during reset");

    // Stalled result stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (foot_valid && foot_stall) |=> foot_valid)
        else $error("result dropped under stall");

    // Stalled result keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (foot_valid && foot_stall) |=> ($stable(foot_x) && $stable(foot_y) && $stable(foot_z)))
        else $error("result changed under stall");

endmodule

bind bezier_foot_swing_trajectory_top bfst_checker u_bfst_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for the quartic Bezier foot trajectory block: directed table, then random swing sweeps.
// Depends on bfst_pkg and bezier_foot_swing_trajectory_top; predicts results the table lacks.

module tb_top;

    import bfst_pkg::*;

    localparam logic MODE_SWING  = 1'b0;
    localparam logic MODE_CORNER = 1'b1;

    // Index 3 is not a register; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    localparam int      SEGMENTS    = 8;
    localparam int      SEG_ITEMS   = 94;
    localparam longint  CYCLE_LIMIT = 400000;

    localparam logic [PHASE_W-1:0] PHASE_ONE = 16'd32768;
    localparam longint ONE_T  = longint'(1) << PHASE_FRAC_BITS;
    localparam longint HALF_T = ONE_T >> 1;

    localparam longint ANG_PI      = PI_Q13;
    localparam longint ANG_TWO_PI  = TWO_PI_Q13;
    localparam longint ANG_HALF_PI = HALF_PI_Q13;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    typedef struct packed {
        logic        [PHASE_W-1:0] phase;
        points_t                   pts;
        logic signed [PITCH_W-1:0] pitch;
    } swing_req_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } foot_pos_t;

    typedef struct {
        logic              mode;
        logic [CLR_W-1:0]  clr1;
        logic [CLR_W-1:0]  clr2;
        swing_req_t        req;
        bit                has_want;
        foot_pos_t         want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       item_valid = 1'b0;
    logic                       item_stall;
    logic        [PHASE_W-1:0]  phase = '0;
    logic signed [POS_W-1:0]    start_x = '0;
    logic signed [POS_W-1:0]    start_y = '0;
    logic signed [POS_W-1:0]    start_z = '0;
    logic signed [POS_W-1:0]    end_x = '0;
    logic signed [POS_W-1:0]    end_y = '0;
    logic signed [POS_W-1:0]    end_z = '0;
    logic signed [PITCH_W-1:0]  pitch = '0;
    logic                       foot_valid;
    logic                       foot_stall = 1'b0;
    logic signed [POS_W-1:0]    foot_x;
    logic signed [POS_W-1:0]    foot_y;
    logic signed [POS_W-1:0]    foot_z;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CLR_W-1:0]           cfg_data = '0;

    // Register copy as the block should hold it
    logic                       cur_mode = MODE_SWING;
    logic [CLR_W-1:0]           cur_clr1 = '0;
    logic [CLR_W-1:0]           cur_clr2 = '0;

    foot_pos_t  pending_feet [$];
    stim_row_t  stim_rows [$];

    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         fail_count = 0;
    int         feet_checked = 0;
    int         requests_sent = 0;
    int         reg_writes = 0;
    longint     cycle_count = 0;

    bezier_foot_swing_trajectory_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .phase      (phase),
        .start_x    (start_x),
        .start_y    (start_y),
        .start_z    (start_z),
        .end_x      (end_x),
        .end_y      (end_y),
        .end_z      (end_z),
        .pitch      (pitch),
        .foot_valid (foot_valid),
        .foot_stall (foot_stall),
        .foot_x     (foot_x),
        .foot_y     (foot_y),
        .foot_z     (foot_z),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // 0.5*sin(pitch) in Q2.16: one 2*pi wrap, fold to the first quadrant, Taylor series
    function automatic longint half_sine_lift(input logic signed [PITCH_W-1:0] ang_in);
        longint             ang;
        bit                 neg;
        longint unsigned    mag, x, x2, h, s, r;
        ang = ang_in;
        if (ang > ANG_PI)
            ang -= ANG_TWO_PI;
        if (ang < -ANG_PI)
            ang += ANG_TWO_PI;
        neg = (ang < 0);
        mag = neg ? -ang : ang;
        if (mag > ANG_HALF_PI)
            mag = ANG_PI - mag;
        x  = mag << 17;
        x2 = (x * x) >> 30;
        h  = ONE_Q30;
        for (int k = 0; k < SINE_ITERS; k++)
            h = ONE_Q30 - ((x2 * h) >> 30) / SINE_DIV[k];
        s = (x * h) >> 30;
        r = (s + (64'd1 << 14)) >> 15;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Weighted sum of five control points, rounded half up, then saturated
    function automatic logic signed [POS_W-1:0] bezier_axis(input longint wt[DEGREE+1],
                                                           input longint pt[DEGREE+1]);
        longint acc, r;
        acc = 0;
        for (int i = 0; i <= DEGREE; i++)
            acc += wt[i] * pt[i];
        r = (acc + HALF_T) >>> PHASE_FRAC_BITS;
        if (r > POS_MAX)
            r = POS_MAX;
        if (r < POS_MIN)
            r = POS_MIN;
        return POS_W'(r);
    endfunction

    function automatic foot_pos_t predict_foot(input swing_req_t rq, input logic mode,
                                               input logic [CLR_W-1:0] clr1,
                                               input logic [CLR_W-1:0] clr2);
        longint unsigned t, u, tt, tu, uu;
        longint unsigned pa [DEGREE+1];
        longint unsigned pb [DEGREE+1];
        longint          wt [DEGREE+1];
        longint          px [DEGREE+1];
        longint          py [DEGREE+1];
        longint          pz [DEGREE+1];
        foot_pos_t       fp;
        t = rq.phase;
        if (t > ONE_T)
            t = ONE_T;
        u  = ONE_T - t;
        tt = (t * t + HALF_T) >> PHASE_FRAC_BITS;
        tu = (t * u + HALF_T) >> PHASE_FRAC_BITS;
        uu = (u * u + HALF_T) >> PHASE_FRAC_BITS;
        pa = '{uu, tu, tu, tt, tt};
        pb = '{uu, uu, tu, tu, tt};
        for (int i = 0; i <= DEGREE; i++)
        begin
            wt[i] = longint'((longint'(BINOM[i]) * pa[i] * pb[i] + HALF_T) >> PHASE_FRAC_BITS);
            if (mode == MODE_SWING)
            begin
                px[i] = (i < 2) ? rq.pts.start_x : rq.pts.end_x;
                py[i] = (i < 2) ? rq.pts.start_y : rq.pts.end_y;
                pz[i] = (i < 2) ? rq.pts.start_z : rq.pts.end_z;
            end
            else
            begin
                px[i] = (i == 0) ? rq.pts.start_x : rq.pts.end_x;
                py[i] = (i == DEGREE) ? rq.pts.end_y : rq.pts.start_y;
                pz[i] = (i == 0) ? rq.pts.start_z : rq.pts.end_z;
            end
        end
        // Lift z control points 1 and 2 in swing mode
        if (mode == MODE_SWING)
        begin
            pz[1] += longint'(clr1);
            pz[2] += longint'(clr2) + half_sine_lift(rq.pitch);
        end
        fp.x = bezier_axis(wt, px);
        fp.y = bezier_axis(wt, py);
        fp.z = bezier_axis(wt, pz);
        return fp;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(9))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2, 3:    return POS_W'($urandom_range(4000) - 2000);
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic points_t rand_points();
        points_t p;
        p.start_x = rand_pos();
        p.start_y = rand_pos();
        p.start_z = rand_pos();
        p.end_x   = rand_pos();
        p.end_y   = rand_pos();
        p.end_z   = rand_pos();
        return p;
    endfunction

    function automatic logic signed [PITCH_W-1:0] rand_pitch();
        case ($urandom_range(7))
            0:       return PITCH_W'($urandom);
            1:       return ($urandom_range(1) == 0) ? PITCH_W'(ANG_PI) : PITCH_W'(-ANG_PI);
            2:       return ($urandom_range(1) == 0) ? PITCH_W'(ANG_HALF_PI)
                                                     : PITCH_W'(-ANG_HALF_PI);
            default: return PITCH_W'(int'($urandom_range(51472)) - 25736);
        endcase
    endfunction

    function automatic logic [PHASE_W-1:0] rand_phase();
        case ($urandom_range(19))
            0:       return '0;
            1:       return PHASE_ONE;
            2:       return PHASE_W'($urandom_range(65535, 32769));
            default: return PHASE_W'($urandom_range(32768));
        endcase
    endfunction

    task automatic add_row(input logic mode, input logic [CLR_W-1:0] clr1,
                           input logic [CLR_W-1:0] clr2, input logic [PHASE_W-1:0] ph,
                           input points_t p, input logic signed [PITCH_W-1:0] pt,
                           input bit has_want, input foot_pos_t want);
        stim_row_t row;
        row.mode      = mode;
        row.clr1      = clr1;
        row.clr2      = clr2;
        row.req.phase = ph;
        row.req.pts   = p;
        row.req.pitch = pt;
        row.has_want  = has_want;
        row.want      = want;
        stim_rows.push_back(row);
    endtask

    // Hold one register write until the block takes it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CLR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CURVE_MODE: cur_mode = data[0];
            CFG_FIRST_CLR:  cur_clr1 = data;
            CFG_SECOND_CLR: cur_clr2 = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Drain the pipeline, then rewrite every register plus the unused index
    task automatic apply_config(input logic mode, input logic [CLR_W-1:0] clr1,
                                input logic [CLR_W-1:0] clr2);
        item_valid <= 1'b0;
        while (pending_feet.size() != 0)
            @(posedge clk);
        write_reg(CFG_CURVE_MODE, CLR_W'(mode));
        write_reg(CFG_FIRST_CLR, clr1);
        write_reg(CFG_SECOND_CLR, clr2);
        write_reg(CFG_SPARE, CLR_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Idle a random while, then hold the request until it is taken
    task automatic drive_request(input swing_req_t rq, input bit has_want, input foot_pos_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pending_feet.push_back(has_want ? want : predict_foot(rq, cur_mode, cur_clr1, cur_clr2));
        item_valid <= 1'b1;
        phase      <= rq.phase;
        start_x    <= rq.pts.start_x;
        start_y    <= rq.pts.start_y;
        start_z    <= rq.pts.start_z;
        end_x      <= rq.pts.end_x;
        end_y      <= rq.pts.end_y;
        end_z      <= rq.pts.end_z;
        pitch      <= rq.pitch;
        do
            @(posedge clk);
        while (item_stall);
        requests_sent++;
    endtask

    task automatic check_field(input string name, input logic signed [POS_W-1:0] want,
                               input logic signed [POS_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Stall the result side at random
    always @(posedge clk)
        foot_stall <= ($urandom_range(99) < recv_stall_pct);

    // Compare each taken result with the oldest expected position
    always @(posedge clk)
    begin
        foot_pos_t want;
        if (rst_n && foot_valid && !foot_stall)
        begin
            feet_checked++;
            if (pending_feet.size() == 0)
            begin
                $error("foot result %0d/%0d/%0d with no request waiting", foot_x, foot_y, foot_z);
                fail_count++;
            end
            else
            begin
                want = pending_feet.pop_front();
                check_field("foot_x", want.x, foot_x);
                check_field("foot_y", want.y, foot_y);
                check_field("foot_z", want.z, foot_z);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        points_t     s1e1, s2e2, maxmin, allmax, allmin;
        swing_req_t  rq;
        points_t     traj;
        logic signed [PITCH_W-1:0] traj_pitch;
        logic        seg_mode [SEGMENTS];
        logic [CLR_W-1:0] seg_clr1 [SEGMENTS];
        logic [CLR_W-1:0] seg_clr2 [SEGMENTS];
        int          sweep_ph, sweep_step;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        s1e1   = '{18'sd1000, -18'sd2000, 18'sd3000, 18'sd5000, 18'sd6000, -18'sd7000};
        s2e2   = '{-18'sd50000, 18'sd40000, -18'sd30000, 18'sd60000, -18'sd70000, 18'sd20000};
        maxmin = '{POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN};
        allmax = '{POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX};
        allmin = '{POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN};

        // Reset settings: ends of the phase, phase clamp, pitch wrap, saturation low
        add_row(MODE_SWING, 0, 0, 0, s1e1, 0, 1, '{18'sd1000, -18'sd2000, 18'sd3000});
        add_row(MODE_SWING, 0, 0, PHASE_ONE, s1e1, 0, 1, '{18'sd5000, 18'sd6000, -18'sd7000});
        add_row(MODE_SWING, 0, 0, 16'd65535, s1e1, 9000, 1,
                '{18'sd5000, 18'sd6000, -18'sd7000});
        add_row(MODE_SWING, 0, 0, 16'd32769, s1e1, -9000, 1,
                '{18'sd5000, 18'sd6000, -18'sd7000});
        add_row(MODE_SWING, 0, 0, 16'd16384, s1e1, 0, 0, '0);
        add_row(MODE_SWING, 0, 0, 16'd16384, s1e1, PITCH_W'(ANG_PI), 0, '0);
        add_row(MODE_SWING, 0, 0, 16'd16384, s1e1, PITCH_W'(-ANG_PI), 0, '0);
        add_row(MODE_SWING, 0, 0, 16'd12000, s1e1, PITCH_W'(ANG_HALF_PI), 0, '0);
        add_row(MODE_SWING, 0, 0, 16'd20000, s1e1, 16'sd32767, 0, '0);
        add_row(MODE_SWING, 0, 0, 16'd20000, s1e1, -16'sd32768, 0, '0);
        add_row(MODE_SWING, 0, 0, 0, maxmin, 0, 1, '{POS_MAX, POS_MAX, POS_MAX});
        add_row(MODE_SWING, 0, 0, PHASE_ONE, maxmin, 0, 1, '{POS_MIN, POS_MIN, POS_MIN});
        add_row(MODE_SWING, 0, 0, 16'd16384, allmin, PITCH_W'(-ANG_HALF_PI), 1,
                '{POS_MIN, POS_MIN, POS_MIN});
        // Full clearances: saturation high, no lift at phase zero
        add_row(MODE_SWING, 16'hFFFF, 16'hFFFF, 16'd16384, allmax, PITCH_W'(ANG_HALF_PI), 1,
                '{POS_MAX, POS_MAX, POS_MAX});
        add_row(MODE_SWING, 16'hFFFF, 16'hFFFF, 0, s1e1, 5000, 1,
                '{18'sd1000, -18'sd2000, 18'sd3000});
        add_row(MODE_SWING, 16'hFFFF, 16'hFFFF, 16'd8192, s1e1, 5000, 0, '0);
        add_row(MODE_SWING, 16'hFFFF, 16'hFFFF, 16'd24576, s2e2, -20000, 0, '0);
        // Corner path
        add_row(MODE_CORNER, 16'hFFFF, 16'hFFFF, 0, s1e1, PITCH_W'(ANG_PI), 1,
                '{18'sd1000, -18'sd2000, 18'sd3000});
        add_row(MODE_CORNER, 16'hFFFF, 16'hFFFF, PHASE_ONE, s1e1, 0, 1,
                '{18'sd5000, 18'sd6000, -18'sd7000});
        add_row(MODE_CORNER, 16'hFFFF, 16'hFFFF, 16'd16384, s1e1, 0, 0, '0);
        add_row(MODE_CORNER, 16'hFFFF, 16'hFFFF, 16'd24576, s2e2, 7000, 0, '0);
        add_row(MODE_CORNER, 16'hFFFF, 16'hFFFF, 16'd16384, allmax, 0, 1,
                '{POS_MAX, POS_MAX, POS_MAX});

        // Walk the directed table, rewriting registers whenever a row needs new settings
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].mode != cur_mode || stim_rows[i].clr1 != cur_clr1
                || stim_rows[i].clr2 != cur_clr2)
                apply_config(stim_rows[i].mode, stim_rows[i].clr1, stim_rows[i].clr2);
            drive_request(stim_rows[i].req, stim_rows[i].has_want, stim_rows[i].want);
        end

        // Random part: settings per segment, extremes first
        seg_mode = '{MODE_SWING, MODE_SWING, MODE_CORNER, MODE_SWING,
                     MODE_CORNER, MODE_SWING, MODE_SWING, MODE_SWING};
        seg_clr1 = '{16'h0000, 16'hFFFF, CLR_W'($urandom), CLR_W'($urandom),
                     16'h0000, 16'h0000, 16'hFFFF, CLR_W'($urandom_range(8000))};
        seg_clr2 = '{16'h0000, 16'hFFFF, CLR_W'($urandom), CLR_W'($urandom),
                     16'h0000, 16'hFFFF, 16'h0000, CLR_W'($urandom_range(8000))};

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            apply_config(seg_mode[seg], seg_clr1[seg], seg_clr2[seg]);
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            sweep_ph = int'(ONE_T) + 1;
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // Start a new swing once the previous sweep passes the end
                if (sweep_ph > ONE_T)
                begin
                    traj       = rand_points();
                    traj_pitch = rand_pitch();
                    sweep_ph   = 0;
                    sweep_step = $urandom_range(8192, 256);
                end
                rq.pts   = traj;
                rq.pitch = traj_pitch;
                rq.phase = PHASE_W'(sweep_ph);
                sweep_ph += sweep_step;
                // Mix in unrelated requests
                if ($urandom_range(3) == 0)
                begin
                    rq.phase = rand_phase();
                    rq.pitch = rand_pitch();
                    if ($urandom_range(1) == 0)
                        rq.pts = rand_points();
                end
                drive_request(rq, 1'b0, '0);
            end
        end

        item_valid <= 1'b0;
        while (pending_feet.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);

        $display("swing and corner curves: %0d requests, %0d foot positions checked,",
                 requests_sent, feet_checked);
        $display("%0d register writes, idle and stall mixes on both channels", reg_writes);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* bezier_foot_swing_trajectory_top.f */
rtl/core/bfst_pkg.sv
rtl/core/bfst_half_sine.sv
rtl/core/bfst_weights.sv
rtl/core/bfst_axis.sv
rtl/core/bezier_foot_swing_trajectory_top.sv
rtl/core/bfst_checker.sv
sim/tb_top.sv
